### rtl/ptd_pkg.sv
// shared types and constants of the polyline turnpoint decoder
`timescale 1ns / 1ps
package ptd_pkg;

    // decode limits
    localparam int unsigned SHIFT_LIMIT_DEF = 30;

    localparam int CHAR_W     = 8;
    localparam int GROUP_W    = 5;
    localparam int ACC_W      = 35;
    localparam int SHIFT_W    = 6;
    localparam int IDX_W      = 3;
    localparam int VAL_W      = 32;
    localparam int NUM_VALUES = 4;
    localparam int SLOT_W     = 2;
    localparam int RAD_W      = 16;

    localparam logic [CHAR_W-1:0]  CHAR_BIAS  = 8'd63;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 6'd63;
    localparam logic [SHIFT_W:0]   SHIFT_STEP = 7'd5;

    // value slots in string order
    localparam logic [SLOT_W-1:0] SLOT_LON = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_LAT = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_ALT = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_RAD = 2'd3;

    // coordinate window in 1e-5 degree
    localparam logic signed [VAL_W-1:0] LAT_MAX_E5 = 32'sd9000000;
    localparam logic signed [VAL_W-1:0] LAT_MIN_E5 = -32'sd9000000;
    localparam logic signed [VAL_W-1:0] LON_MAX_E5 = 32'sd18000000;
    localparam logic signed [VAL_W-1:0] LON_MIN_E5 = -32'sd18000000;

    localparam logic [RAD_W-1:0] RAD_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_TRUNC      = 3'd1,
        ERR_LONG       = 3'd2,
        ERR_COUNT      = 3'd3,
        ERR_NEG_RADIUS = 3'd4,
        ERR_RANGE      = 3'd5
    } t_err;

    typedef struct packed {
        logic [CHAR_W-1:0] char_byte;
        logic              is_last;
    } t_char_beat;

    typedef struct packed {
        logic                    valid_res;
        t_err                    error_kind;
        logic signed [VAL_W-1:0] lon_e5;
        logic signed [VAL_W-1:0] lat_e5;
        logic signed [VAL_W-1:0] alt_m;
        logic [RAD_W-1:0]        cyl_radius;
    } t_result_beat;

    // end-of-string snapshot handed from accumulator to checker
    typedef struct packed {
        t_err                                 err;
        logic [NUM_VALUES-1:0][VAL_W-1:0]     vals;
    } t_snap;

endpackage

### rtl/ptd_char_if.sv
// character stream channel
`timescale 1ns / 1ps
interface ptd_char_if import ptd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_char_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ptd_result_if.sv
// decoded turnpoint result channel
`timescale 1ns / 1ps
interface ptd_result_if import ptd_pkg::*; ();
    logic         valid;
    logic         ready;
    t_result_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ptd_accum.sv
// input register, per-character varint gathering and end-of-string snapshot
`timescale 1ns / 1ps
module ptd_accum import ptd_pkg::*; #(
    parameter int unsigned SHIFT_LIMIT = SHIFT_LIMIT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptd_char_if.sink   i_in,
    output logic       o_snap_vld,
    output t_snap      o_snap,
    input  logic       i_snap_rdy
);

    logic                             r_in_vld;
    t_char_beat                       r_in;
    logic [IDX_W-1:0]                 r_idx,   n_idx;
    logic [SHIFT_W-1:0]               r_shift, n_shift;
    logic [ACC_W-1:0]                 r_acc,   n_acc;
    t_err                             r_err,   n_err;
    logic [NUM_VALUES-1:0][VAL_W-1:0] r_vals,  n_vals;
    logic                             r_snap_vld;
    t_snap                            r_snap;

    logic [CHAR_W-1:0]  w_bits;
    logic [ACC_W-1:0]   w_acc_or;
    logic [SHIFT_W:0]   w_shift_sum;
    logic               w_snap_rdy;
    logic               w_consume;
    logic               w_load_snap;
    t_err               w_base_err;

    always_comb begin
        w_bits      = r_in.char_byte - CHAR_BIAS;
        w_acc_or    = r_acc | (ACC_W'(w_bits[GROUP_W-1:0]) << r_shift);
        w_shift_sum = {1'b0, r_shift} + SHIFT_STEP;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_acc   = r_acc;
        n_err   = r_err;
        n_vals  = r_vals;
        if (r_err != ERR_NONE) begin
            // sticky: ignore until end of string
        end else if (r_idx >= IDX_W'(NUM_VALUES)) begin
            n_err = ERR_COUNT;
        end else if (r_shift > SHIFT_W'(SHIFT_LIMIT)) begin
            n_err = ERR_LONG;
        end else if (w_bits[CHAR_W-1:GROUP_W] != '0) begin
            // continue bit set
            n_acc   = w_acc_or;
            n_shift = (w_shift_sum > {1'b0, SHIFT_MAX}) ? SHIFT_MAX
                                                        : w_shift_sum[SHIFT_W-1:0];
        end else begin
            // last group: zigzag decode into the next slot
            n_vals[r_idx[SLOT_W-1:0]] = w_acc_or[VAL_W:1] ^ {VAL_W{w_acc_or[0]}};
            n_idx   = IDX_W'(r_idx + IDX_W'(1));
            n_shift = '0;
            n_acc   = '0;
        end

        if (n_err != ERR_NONE) begin
            w_base_err = n_err;
        end else if (n_shift != '0 || n_acc != '0) begin
            w_base_err = ERR_TRUNC;
        end else if (n_idx != IDX_W'(NUM_VALUES)) begin
            w_base_err = ERR_COUNT;
        end else begin
            w_base_err = ERR_NONE;
        end
    end

    assign w_snap_rdy  = !r_snap_vld || i_snap_rdy;
    assign w_consume   = r_in_vld && (!r_in.is_last || w_snap_rdy);
    assign w_load_snap = w_consume && r_in.is_last;
    assign i_in.ready  = !r_in_vld || w_consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_idx      <= '0;
            r_shift    <= '0;
            r_acc      <= '0;
            r_err      <= ERR_NONE;
            r_snap_vld <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_vld <= i_in.valid;
            end
            if (w_consume) begin
                if (r_in.is_last) begin
                    r_idx   <= '0;
                    r_shift <= '0;
                    r_acc   <= '0;
                    r_err   <= ERR_NONE;
                end else begin
                    r_idx   <= n_idx;
                    r_shift <= n_shift;
                    r_acc   <= n_acc;
                    r_err   <= n_err;
                end
            end
            if (w_load_snap) begin
                r_snap_vld <= 1'b1;
            end else if (i_snap_rdy) begin
                r_snap_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (w_consume) begin
            r_vals <= n_vals;
        end
        if (w_load_snap) begin
            r_snap.err  <= w_base_err;
            r_snap.vals <= n_vals;
        end
    end

    assign o_snap_vld = r_snap_vld;
    assign o_snap     = r_snap;

endmodule

### rtl/ptd_check.sv
// final radius and coordinate checks and the result register
`timescale 1ns / 1ps
module ptd_check import ptd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_vld,
    input  t_snap       i_snap,
    output logic        o_snap_rdy,
    ptd_result_if.source o_out
);

    logic                    r_out_vld;
    t_result_beat            r_out;
    t_result_beat            n_out;
    logic signed [VAL_W-1:0] w_lon;
    logic signed [VAL_W-1:0] w_lat;
    logic [VAL_W-1:0]        w_rad;
    t_err                    w_err;

    always_comb begin
        w_lon = $signed(i_snap.vals[SLOT_LON]);
        w_lat = $signed(i_snap.vals[SLOT_LAT]);
        w_rad = i_snap.vals[SLOT_RAD];
        w_err = i_snap.err;
        if (w_err == ERR_NONE) begin
            if (w_rad[VAL_W-1]) begin
                w_err = ERR_NEG_RADIUS;
            end else if (w_lat < LAT_MIN_E5 || w_lat > LAT_MAX_E5 ||
                         w_lon < LON_MIN_E5 || w_lon > LON_MAX_E5) begin
                w_err = ERR_RANGE;
            end
        end
        n_out = '0;
        n_out.error_kind = w_err;
        if (w_err == ERR_NONE) begin
            n_out.valid_res  = 1'b1;
            n_out.lon_e5     = w_lon;
            n_out.lat_e5     = w_lat;
            n_out.alt_m      = $signed(i_snap.vals[SLOT_ALT]);
            n_out.cyl_radius = (w_rad[VAL_W-1:RAD_W] != '0) ? RAD_SAT : w_rad[RAD_W-1:0];
        end
    end

    assign o_snap_rdy = !r_out_vld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_snap_rdy) begin
            r_out_vld <= i_snap_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_rdy && i_snap_vld) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

endmodule

### rtl/polyline_turnpoint_decoder_unit.sv
// top level of the polyline turnpoint decoder
`timescale 1ns / 1ps
// decodes one encoded turnpoint string, one character per input beat, the
// last character flagged by is_last. each character minus 63 gives five data
// bits and a continue bit; the groups build four zigzag-signed values in the
// order longitude, latitude, altitude, radius. one result beat leaves per
// string: either the turnpoint (coordinates in 1e-5 degree, radius clipped to
// 65535) or an error code with all value fields zero. SHIFT_LIMIT bounds how
// far one value may grow before it counts as too long. the block takes one
// character every cycle, sustained, also while one result waits at the
// output; only the last character of a further string stalls, when both the
// snapshot and the result register are still full. a result is presented
// once its last character has passed the input register, the gathering
// stage with end-of-string snapshot and the check stage with result
// register. the per-character gathering register loop sets the character
// rate. ready runs back combinationally from the output through the three
// stage registers, so a stalled sink holds the pipe.
module polyline_turnpoint_decoder_unit import ptd_pkg::*; #(
    parameter int unsigned SHIFT_LIMIT = SHIFT_LIMIT_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ptd_char_if.sink     i_in,
    ptd_result_if.source o_out
);

    // snapshot hand-off between the gathering and check stages
    logic  w_snap_vld;
    logic  w_snap_rdy;
    t_snap w_snap;

    ptd_accum #(
        .SHIFT_LIMIT (SHIFT_LIMIT)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_snap_vld (w_snap_vld),
        .o_snap     (w_snap),
        .i_snap_rdy (w_snap_rdy)
    );

    ptd_check u_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_snap_vld (w_snap_vld),
        .i_snap     (w_snap),
        .o_snap_rdy (w_snap_rdy),
        .o_out      (o_out)
    );

endmodule
